// ===== design/strict_decimal_integer_parser_defines.svh =====
// ---------------------------------------------------------------------------
// strict_decimal_integer_parser_defines
// Assertion macros shared by the decimal parser. Each macro samples on clk
// and is disabled while rst_n is low, both taken from the enclosing scope.
// ---------------------------------------------------------------------------
`ifndef STRICT_DECIMAL_INTEGER_PARSER_DEFINES_SVH
`define STRICT_DECIMAL_INTEGER_PARSER_DEFINES_SVH

// Check a condition that must hold in the same cycle as its trigger.
`define SDIP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a condition that must hold in the cycle after its trigger.
`define SDIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sdip_pkg.sv =====
// ---------------------------------------------------------------------------
// sdip_pkg
// Types and constants for the strict decimal integer parser: item layouts,
// parse phases, status codes, register indexes and character codes.
// ---------------------------------------------------------------------------
package sdip_pkg;

    // Input item: one character of the field
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
        logic       value_absent;
    } text_item_t;

    // Result item: value and status
    typedef struct packed {
        logic signed [63:0] parsed_value;
        logic [2:0]         status;
    } result_item_t;

    // Parse phases
    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_WS    = 3'd1,
        PH_SIGN  = 3'd2,
        PH_DIG   = 3'd3,
        PH_TRAIL = 3'd4,
        PH_NAN   = 3'd5
    } phase_t;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MISSING = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_OVF     = 3'd3;
    localparam logic [2:0] ST_NAN     = 3'd4;
    localparam logic [2:0] ST_TRAIL   = 3'd5;
    localparam logic [2:0] ST_RANGE   = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_MIN_VALUE = 2'd0;
    localparam logic [1:0] CFG_MAX_VALUE = 2'd1;

    // Register reset values
    localparam logic signed [63:0] MIN_VALUE_RESET = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] MAX_VALUE_RESET = 64'sh7FFF_FFFF_FFFF_FFFF;

    // Magnitude limits for each sign
    localparam logic [63:0] MAG_LIMIT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAG_LIMIT_NEG = 64'h8000_0000_0000_0000;

    // Character codes
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Running parse state
    typedef struct packed {
        phase_t      phase;
        logic        is_negative;
        logic [63:0] magnitude;
        logic        overflowed;
        logic        junk_seen;
    } parse_state_t;

    // Snapshot of a finished field, handed to the finish stage
    typedef struct packed {
        logic         value_absent;
        parse_state_t st;
    } fin_snap_t;

    localparam parse_state_t PARSE_CLEAR = '{
        phase:       PH_LEAD,
        is_negative: 1'b0,
        magnitude:   64'd0,
        overflowed:  1'b0,
        junk_seen:   1'b0
    };

endpackage

// ===== design/sdip_parse.sv =====
// ---------------------------------------------------------------------------
// sdip_parse
// Character consumer: holds the running parse state and computes the state
// after the current character, including the times-ten accumulate and the
// saturating overflow check.
// ---------------------------------------------------------------------------
module sdip_parse
    import sdip_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step_en,
    input  text_item_t   item,
    output parse_state_t state,
    output parse_state_t state_next
);

    parse_state_t state_reg;
    logic [7:0]   c;
    logic         c_blank;
    logic         c_space;
    logic         c_digit;
    logic         c_sign;
    logic [63:0]  limit;
    logic [67:0]  mag_x10;
    logic         add_ovf;
    logic [63:0]  add_mag;

    assign c = item.text_byte;

    // Classify the character
    always_comb
    begin
        c_blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
        c_space = (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]});
        c_digit = c inside {[CHAR_ZERO:CHAR_NINE]};
        c_sign  = (c == CHAR_PLUS) || (c == CHAR_MINUS);
    end

    // Accumulate one digit; saturate at the limit for the sign
    always_comb
    begin
        limit   = state_reg.is_negative ? MAG_LIMIT_NEG : MAG_LIMIT_POS;
        mag_x10 = {1'b0, state_reg.magnitude, 3'b000}
                + {3'b000, state_reg.magnitude, 1'b0}
                + {64'd0, c[3:0]};
        add_ovf = state_reg.overflowed || (mag_x10 > {4'd0, limit});
        add_mag = add_ovf ? limit : mag_x10[63:0];
    end

    // Advance the phase for this character
    always_comb
    begin
        state_next = state_reg;
        case (state_reg.phase)
            PH_LEAD, PH_WS:
            begin
                if (state_reg.phase == PH_LEAD && c_blank)
                begin
                    state_next.phase = PH_LEAD;
                end
                else if (c_space)
                begin
                    state_next.phase = PH_WS;
                end
                else if (c_sign)
                begin
                    state_next.is_negative = (c == CHAR_MINUS);
                    state_next.phase       = PH_SIGN;
                end
                else if (c_digit)
                begin
                    state_next.magnitude  = add_mag;
                    state_next.overflowed = add_ovf;
                    state_next.phase      = PH_DIG;
                end
                else
                begin
                    state_next.phase = PH_NAN;
                end
            end
            PH_SIGN:
            begin
                if (c_digit)
                begin
                    state_next.magnitude  = add_mag;
                    state_next.overflowed = add_ovf;
                    state_next.phase      = PH_DIG;
                end
                else
                begin
                    state_next.phase = PH_NAN;
                end
            end
            PH_DIG:
            begin
                if (c_digit)
                begin
                    state_next.magnitude  = add_mag;
                    state_next.overflowed = add_ovf;
                end
                else
                begin
                    if (!c_blank)
                    begin
                        state_next.junk_seen = 1'b1;
                    end
                    state_next.phase = PH_TRAIL;
                end
            end
            PH_TRAIL:
            begin
                if (!c_blank)
                begin
                    state_next.junk_seen = 1'b1;
                end
            end
            default:
            begin
                state_next.phase = PH_NAN;
            end
        endcase
    end

    // Hold the state; clear it when a field ends or is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PARSE_CLEAR;
        end
        else if (step_en)
        begin
            if (item.last_byte || item.value_absent)
            begin
                state_reg <= PARSE_CLEAR;
            end
            else
            begin
                state_reg <= state_next;
            end
        end
    end

    assign state = state_reg;

endmodule

// ===== design/sdip_finish.sv =====
// ---------------------------------------------------------------------------
// sdip_finish
// Field finisher: turns a finished parse snapshot into the value and status,
// applying the sign and the configured range check.
// ---------------------------------------------------------------------------
module sdip_finish
    import sdip_pkg::*;
(
    input  fin_snap_t          snap,
    input  logic signed [63:0] min_value,
    input  logic signed [63:0] max_value,
    output result_item_t       result
);

    logic signed [63:0] value;
    logic               out_of_range;

    // Apply the sign and check the range
    always_comb
    begin
        value = snap.st.is_negative ? $signed(~snap.st.magnitude + 64'd1)
                                    : $signed(snap.st.magnitude);
        out_of_range = (value < min_value) || (value > max_value);
    end

    // Pick the status in priority order
    always_comb
    begin
        result.parsed_value = 64'sd0;
        if (snap.value_absent)
        begin
            result.status = ST_MISSING;
        end
        else if (snap.st.phase == PH_LEAD)
        begin
            result.status = ST_EMPTY;
        end
        else if (snap.st.phase != PH_DIG && snap.st.phase != PH_TRAIL)
        begin
            result.status = ST_NAN;
        end
        else if (snap.st.overflowed)
        begin
            result.status = ST_OVF;
        end
        else if (snap.st.junk_seen)
        begin
            result.status = ST_TRAIL;
        end
        else if (out_of_range)
        begin
            result.status = ST_RANGE;
        end
        else
        begin
            result.status       = ST_OK;
            result.parsed_value = value;
        end
    end

endmodule

// ===== design/strict_decimal_integer_parser.sv =====
// ---------------------------------------------------------------------------
// strict_decimal_integer_parser
// Parses a base-10 signed 64-bit integer from a text field streamed one
// character per item, and emits one result item per finished or absent field.
// ---------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  text      in         text_valid/text_ready   text_item (byte, last, absent)
//  result    out        result_valid/result_ready result_item (value, status)
//  cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One character item per cycle, sustained. After a field's last item is
// accepted, its result passes through the input register, the parse/snapshot
// register and the result register. The times-ten accumulate with overflow
// compare sets the parse stage; the sign and range compare set the finish stage.
// Reset clears the parse state and loads the full 64-bit range; no clearing
// pass. A stalled result stops only end-of-field items; other characters flow.
// ---------------------------------------------------------------------------
`include "strict_decimal_integer_parser_defines.svh"

module strict_decimal_integer_parser
    import sdip_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         text_valid,
    output logic         text_ready,
    input  text_item_t   text_item,
    output logic         result_valid,
    input  logic         result_ready,
    output result_item_t result_item,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    logic               in_valid_reg;
    text_item_t         in_item_reg;
    logic               in_is_end;
    logic               in_adv;
    logic               fin_valid_reg;
    fin_snap_t          fin_snap_reg;
    logic               fin_ready;
    logic               out_free;
    logic               result_valid_reg;
    result_item_t       result_item_reg;
    result_item_t       fin_result;
    parse_state_t       parse_state;
    parse_state_t       parse_state_next;
    logic signed [63:0] min_value_reg;
    logic signed [63:0] max_value_reg;

    // Stage handshakes
    assign in_is_end  = in_item_reg.last_byte || in_item_reg.value_absent;
    assign out_free   = !result_valid_reg || result_ready;
    assign fin_ready  = !fin_valid_reg || out_free;
    assign in_adv     = in_valid_reg && (!in_is_end || fin_ready);
    assign text_ready = !in_valid_reg || in_adv;
    assign cfg_ready  = 1'b1;

    // Write the range registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_value_reg <= MIN_VALUE_RESET;
            max_value_reg <= MAX_VALUE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIN_VALUE: min_value_reg <= $signed(cfg_data);
                CFG_MAX_VALUE: max_value_reg <= $signed(cfg_data);
                default:       ;
            endcase
        end
    end

    // Hold the input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text_ready)
        begin
            in_valid_reg <= text_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_ready && text_valid)
        begin
            in_item_reg <= text_item;
        end
    end

    // Consume characters
    sdip_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (in_adv),
        .item       (in_item_reg),
        .state      (parse_state),
        .state_next (parse_state_next)
    );

    // Capture the finished field
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (fin_ready)
        begin
            fin_valid_reg <= in_adv && in_is_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && in_is_end)
        begin
            fin_snap_reg <= '{value_absent: in_item_reg.value_absent,
                              st:           parse_state_next};
        end
    end

    // Build the result
    sdip_finish u_finish (
        .snap      (fin_snap_reg),
        .min_value (min_value_reg),
        .max_value (max_value_reg),
        .result    (fin_result)
    );

    // Hold the result item until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            result_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && fin_valid_reg)
        begin
            result_item_reg <= fin_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

    // Checks
    `SDIP_ASSERT_SAME(a_in_stall_only_on_end,
        in_valid_reg && !in_adv,
        in_is_end && fin_valid_reg && !out_free,
        "input stage stalled without a blocked end item")
    `SDIP_ASSERT_NEXT(a_clear_after_end,
        in_adv && in_is_end,
        parse_state.phase == PH_LEAD && parse_state.magnitude == 64'd0
            && !parse_state.overflowed,
        "parse state not cleared after field end")
    `SDIP_ASSERT_SAME(a_overflow_saturates,
        parse_state.overflowed,
        parse_state.magnitude == (parse_state.is_negative ? MAG_LIMIT_NEG : MAG_LIMIT_POS),
        "overflowed magnitude not saturated")
    `SDIP_ASSERT_SAME(a_value_zero_on_error,
        result_valid_reg && result_item_reg.status != ST_OK,
        result_item_reg.parsed_value == 64'sd0,
        "nonzero value with error status")

endmodule

// ===== sim/strict_decimal_integer_parser_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// strict_decimal_integer_parser_tb
// Streams text fields into the decimal parser one character item at a time
// and checks every result against a predictor that parses the same fields.
// Directed fields cover the syntax corners and the register extremes. Random
// fields, mostly well-formed numbers with some noise, run under three idling
// modes. One test holds the result side off long enough for the input to stall.
// ---------------------------------------------------------------------------
module strict_decimal_integer_parser_tb;
    import sdip_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 5;
    localparam int PIPE_SETTLE     = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_ERROR_LINES = 20;
    localparam logic [63:0] DECIMAL_BASE = 64'd10;

    // Whitespace and odd characters not named in the package
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_VT  = 8'h0B;
    localparam logic [7:0] CHAR_FF  = 8'h0C;
    localparam logic [7:0] CHAR_TOP = 8'hFF;

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               text_valid   = 1'b0;
    logic               text_ready;
    text_item_t         text_item    = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    result_item_t       result_item;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index    = CFG_MIN_VALUE;
    logic [63:0]        cfg_data     = '0;

    // Predictor state: the field being parsed and the accepted range
    phase_t             acc_phase    = PH_LEAD;
    logic               acc_negative = 1'b0;
    logic [63:0]        acc_magnitude = '0;
    logic               acc_overflow = 1'b0;
    logic               acc_junk     = 1'b0;
    logic signed [63:0] range_min    = MIN_VALUE_RESET;
    logic signed [63:0] range_max    = MAX_VALUE_RESET;

    result_item_t       expected_parses[$];
    logic [7:0]         field_chars[$];

    int                 send_idle_pct     = 0;
    int                 recv_idle_pct     = 0;
    int                 hold_off_requests = 0;
    int                 hold_off_served   = 0;
    int                 hold_off_left     = 0;
    int                 items_sent        = 0;
    int                 results_checked   = 0;
    int                 range_settings    = 0;
    int                 mismatch_count    = 0;
    int                 cycle_count       = 0;

    strict_decimal_integer_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text_item    (text_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Field parser predictor
    // -----------------------------------------------------------------------
    function automatic bit is_blank_char(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB;
    endfunction

    function automatic bit is_space_char(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic bit is_digit_char(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic void clear_field();
        acc_phase     = PH_LEAD;
        acc_negative  = 1'b0;
        acc_magnitude = '0;
        acc_overflow  = 1'b0;
        acc_junk      = 1'b0;
    endfunction

    // Multiply by ten and add; saturate at the limit for the sign
    function automatic void accumulate_digit(input logic [7:0] c);
        logic [63:0] limit;
        logic [63:0] digit;
        limit = acc_negative ? MAG_LIMIT_NEG : MAG_LIMIT_POS;
        digit = {56'd0, c - CHAR_ZERO};
        if (acc_overflow || acc_magnitude > (limit - digit) / DECIMAL_BASE)
        begin
            acc_overflow  = 1'b1;
            acc_magnitude = limit;
        end
        else
            acc_magnitude = acc_magnitude * DECIMAL_BASE + digit;
    endfunction

    function automatic void start_number(input logic [7:0] c);
        if (c == CHAR_PLUS || c == CHAR_MINUS)
        begin
            acc_negative = (c == CHAR_MINUS);
            acc_phase    = PH_SIGN;
        end
        else if (is_digit_char(c))
        begin
            accumulate_digit(c);
            acc_phase = PH_DIG;
        end
        else
            acc_phase = PH_NAN;
    endfunction

    function automatic void consume_char(input logic [7:0] c);
        case (acc_phase)
            PH_LEAD:
            begin
                if (is_blank_char(c))
                    ;
                else if (is_space_char(c))
                    acc_phase = PH_WS;
                else
                    start_number(c);
            end
            PH_WS:
            begin
                if (!is_space_char(c))
                    start_number(c);
            end
            PH_SIGN:
            begin
                if (is_digit_char(c))
                begin
                    accumulate_digit(c);
                    acc_phase = PH_DIG;
                end
                else
                    acc_phase = PH_NAN;
            end
            PH_DIG:
            begin
                if (is_digit_char(c))
                    accumulate_digit(c);
                else
                begin
                    if (!is_blank_char(c))
                        acc_junk = 1'b1;
                    acc_phase = PH_TRAIL;
                end
            end
            PH_TRAIL:
            begin
                if (!is_blank_char(c))
                    acc_junk = 1'b1;
            end
            default:
                acc_phase = PH_NAN;
        endcase
    endfunction

    // Status priority: empty, not a number, overflow, trailing, range
    function automatic result_item_t finish_field();
        result_item_t       res;
        logic signed [63:0] value;
        res.parsed_value = '0;
        res.status       = ST_OK;
        value = acc_negative ? (64'd0 - acc_magnitude) : acc_magnitude;
        if (acc_phase == PH_LEAD)
            res.status = ST_EMPTY;
        else if (acc_phase != PH_DIG && acc_phase != PH_TRAIL)
            res.status = ST_NAN;
        else if (acc_overflow)
            res.status = ST_OVF;
        else if (acc_junk)
            res.status = ST_TRAIL;
        else if (value < range_min || value > range_max)
            res.status = ST_RANGE;
        else
            res.parsed_value = value;
        return res;
    endfunction

    function automatic void predict_item(input text_item_t item);
        result_item_t res;
        if (item.value_absent)
        begin
            clear_field();
            res.parsed_value = '0;
            res.status       = ST_MISSING;
            expected_parses.push_back(res);
        end
        else
        begin
            consume_char(item.text_byte);
            if (item.last_byte)
            begin
                expected_parses.push_back(finish_field());
                clear_field();
            end
        end
    endfunction

    // -----------------------------------------------------------------------
    // Result side: random stalls, long hold-off on request, checking
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_off_served != hold_off_requests)
        begin
            hold_off_served = hold_off_requests;
            hold_off_left   = HOLD_OFF_CYCLES;
        end
        if (hold_off_left != 0)
        begin
            hold_off_left--;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        result_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_checked++;
            if (expected_parses.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_ERROR_LINES)
                    $display("%0t unexpected result: value %0d status %0d", $time,
                             result_item.parsed_value, result_item.status);
            end
            else
            begin
                want = expected_parses.pop_front();
                if (result_item.parsed_value !== want.parsed_value)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_ERROR_LINES)
                        $display("%0t parsed_value: expected %0d, actual %0d", $time,
                                 want.parsed_value, result_item.parsed_value);
                end
                if (result_item.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_ERROR_LINES)
                        $display("%0t status: expected %0d, actual %0d", $time,
                                 want.status, result_item.status);
                end
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t run stopped after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_parses.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Drivers
    // -----------------------------------------------------------------------
    // Offer one item, idling at random first; predict it once accepted
    task automatic send_item(input logic [7:0] ch, input logic last, input logic absent);
        text_item_t item;
        item.text_byte    = ch;
        item.last_byte    = last;
        item.value_absent = absent;
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid <= 1'b1;
        text_item  <= item;
        @(posedge clk);
        while (!text_ready)
            @(posedge clk);
        predict_item(item);
        items_sent++;
    endtask

    // Send the built field; leave it open when close_field is clear
    task automatic send_field(input bit close_field);
        for (int i = 0; i < field_chars.size(); i++)
            send_item(field_chars[i], close_field && (i == field_chars.size() - 1), 1'b0);
        field_chars.delete();
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            field_chars.push_back(s[i]);
    endfunction

    task automatic send_text(input string s);
        add_text(s);
        send_field(1'b1);
    endtask

    task automatic send_absent();
        send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    endtask

    // Hold the input low until every expected result is back, then settle
    task automatic drain_results();
        text_valid <= 1'b0;
        @(posedge clk);
        while (expected_parses.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // Write both range registers back to back; call only when idle
    task automatic set_range(input logic signed [63:0] lo, input logic signed [63:0] hi);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MIN_VALUE;
        cfg_data  <= lo;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        range_min = lo;
        cfg_index <= CFG_MAX_VALUE;
        cfg_data  <= hi;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        range_max = hi;
        cfg_valid <= 1'b0;
        range_settings++;
    endtask

    // -----------------------------------------------------------------------
    // Random field builders
    // -----------------------------------------------------------------------
    function automatic void add_blanks(input int most);
        repeat ($urandom_range(most))
            field_chars.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
    endfunction

    // Optional blanks and whitespace, optional sign, digits, optional blanks
    function automatic void add_number();
        logic [63:0] mag;
        int          pick;
        add_blanks(2);
        if ($urandom_range(9) == 0)
            field_chars.push_back(8'($urandom_range(CHAR_TAB, CHAR_CR)));
        pick = $urandom_range(9);
        if (pick < 3)
            field_chars.push_back(CHAR_PLUS);
        else if (pick < 6)
            field_chars.push_back(CHAR_MINUS);
        if ($urandom_range(9) == 0)
            add_text("00");
        pick = $urandom_range(99);
        if (pick < 85)
        begin
            if (pick < 45)
                mag = 64'($urandom_range(1000));
            else if (pick < 65)
                mag = {$urandom, $urandom};
            else
                mag = MAG_LIMIT_POS - 64'd3 + 64'($urandom_range(6));
            add_text($sformatf("%0d", mag));
        end
        else
        begin
            // long digit runs, mostly past the limit
            field_chars.push_back(8'(CHAR_ZERO + $urandom_range(1, 9)));
            repeat ($urandom_range(18, 23))
                field_chars.push_back(8'(CHAR_ZERO + $urandom_range(9)));
        end
        add_blanks(2);
    endfunction

    task automatic send_random_field();
        int kind;
        kind = $urandom_range(99);
        if (kind < 60)
        begin
            add_number();
            send_field(1'b1);
        end
        else if (kind < 75)
        begin
            // well-formed number with one character replaced or appended
            add_number();
            if ($urandom_range(1))
                field_chars[$urandom_range(field_chars.size() - 1)] = 8'($urandom_range(255));
            else
                field_chars.push_back(8'($urandom_range(255)));
            send_field(1'b1);
        end
        else if (kind < 87)
        begin
            repeat ($urandom_range(1, 6))
                field_chars.push_back(8'($urandom_range(255)));
            send_field(1'b1);
        end
        else if (kind < 92)
        begin
            add_blanks(3);
            if ($urandom_range(2) == 0)
                field_chars.push_back(8'($urandom_range(CHAR_TAB, CHAR_CR)));
            if (field_chars.size() == 0)
                field_chars.push_back(CHAR_SPACE);
            send_field(1'b1);
        end
        else
        begin
            // abandon a partial field now and then
            if ($urandom_range(1))
            begin
                add_number();
                send_field(1'b0);
            end
            send_absent();
        end
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    task automatic test_number_syntax();
        send_text("0");
        send_text("9223372036854775807");
        send_text("-9223372036854775808");
        send_text("9223372036854775808");
        send_text("-9223372036854775809");
        send_text("18446744073709551616");
        send_text(" \t+42");
        field_chars.push_back(CHAR_LF);
        send_text(" -7");
        field_chars.push_back(CHAR_VT);
        field_chars.push_back(CHAR_FF);
        send_text("-0");
        field_chars.push_back(CHAR_CR);
        send_text("5");
        send_text("-");
        send_text("+");
        send_text("- 5");
        send_text("+-5");
        send_text("abc");
        send_text("12x");
        send_text("12 \t");
        send_text("12 3");
        send_text("99999999999999999999999x");
        send_text("007");
        send_text("   ");
        send_text("\t");
        field_chars.push_back(CHAR_LF);
        send_field(1'b1);
        // byte zero is an ordinary character
        field_chars.push_back(CHAR_NUL);
        send_field(1'b1);
        add_text("1");
        field_chars.push_back(CHAR_NUL);
        send_field(1'b1);
        field_chars.push_back(CHAR_TOP);
        send_text("1");
        send_absent();
        add_text("12");
        send_field(1'b0);
        send_absent();
    endtask

    task automatic test_range_limits();
        drain_results();
        set_range(-64'sd100, 64'sd100);
        send_text("-100");
        send_text("100");
        send_text("101");
        send_text("-101");
        send_text(" -0 ");
        // inverted window rejects everything
        drain_results();
        set_range(64'sd5, -64'sd5);
        send_text("0");
        send_text("5");
        drain_results();
        set_range(MAX_VALUE_RESET, MAX_VALUE_RESET);
        send_text("9223372036854775807");
        send_text("9223372036854775806");
        drain_results();
        set_range(MIN_VALUE_RESET, MIN_VALUE_RESET);
        send_text("-9223372036854775808");
        send_text("-1");
        drain_results();
        set_range(MIN_VALUE_RESET, MAX_VALUE_RESET);
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int item_budget);
        int                 base_items;
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        base_items    = items_sent;
        for (int window = 0; window < 3; window++)
        begin
            drain_results();
            if (window == 0)
            begin
                lo = MIN_VALUE_RESET;
                hi = MAX_VALUE_RESET;
            end
            else if (window == 1)
            begin
                lo = 64'($urandom_range(1000));
                lo = -lo;
                hi = 64'($urandom_range(1000));
            end
            else
            begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
            end
            set_range(lo, hi);
            while (items_sent - base_items < item_budget * (window + 1) / 3)
                send_random_field();
        end
    endtask

    // Stall the result side long enough for the input to back up
    task automatic test_backpressure();
        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_requests++;
        repeat (40)
        begin
            field_chars.push_back(8'(CHAR_ZERO + $urandom_range(9)));
            send_field(1'b1);
        end
        drain_results();
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 8;
        recv_idle_pct = 74;
        test_number_syntax();
        test_range_limits();
        test_random_traffic(8, 74, 140);
        test_random_traffic(74, 8, 130);
        test_backpressure();
        test_random_traffic(0, 0, 130);
        drain_results();
        $display("Parsed %0d character items into %0d results across %0d range settings,",
                 items_sent, results_checked, range_settings);
        $display("with idling on either side, a long result stall and %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0 && expected_parses.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
